// File: rtl/sbce_pkg.sv
// shared types and constants for the six-bit character encoder
`timescale 1ns / 1ps
`default_nettype none

package sbce_pkg;

  localparam logic [7:0] CHAR_BASE = 8'h30;
  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [5:0] DIGIT_MASK = 6'h3F;
  localparam logic [31:0] SAT_LIMIT_1 = 32'h0000_003F;
  localparam logic [31:0] SAT_LIMIT_2 = 32'h0000_0FFF;
  localparam logic [31:0] SAT_LIMIT_3 = 32'h0003_FFFF;
  localparam logic [31:0] SAT_LIMIT_4 = 32'h00FF_FFFF;
  localparam logic [2:0] CHARS_RESET = 3'd3;
  localparam logic [2:0] MAX_RESULTS = 3'd7;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] value;
    logic        last_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_beat_t;

  // one classified value: digits left-aligned, digit count minus one
  typedef struct packed {
    logic [23:0] digits;
    logic [1:0]  rem;
    logic        last;
  } job_t;

  typedef enum logic [1:0] {
    PH_DIGIT,
    PH_CHK,
    PH_LF
  } phase_t;

endpackage

`default_nettype wire

// File: rtl/sbce_front.sv
// front end: saturates each value and left-aligns its digits
`timescale 1ns / 1ps
`default_nettype none

module sbce_front
  import sbce_pkg::*;
(
  input  wire in_beat_t   item,
  input  wire logic [2:0] chars_per_value,
  output job_t            job
);

  logic [1:0]  rem;
  logic [31:0] limit;
  logic [31:0] sat;

  always_comb begin
    if (chars_per_value == 3'd0) begin
      rem = 2'd0;
    end else if (chars_per_value > 3'd4) begin
      rem = 2'd3;
    end else begin
      rem = 2'(chars_per_value - 3'd1);
    end
  end

  always_comb begin
    unique case (rem)
      2'd0: limit = SAT_LIMIT_1;
      2'd1: limit = SAT_LIMIT_2;
      2'd2: limit = SAT_LIMIT_3;
      default: limit = SAT_LIMIT_4;
    endcase
  end

  assign sat = (item.value > limit) ? limit : item.value;

  always_comb begin
    job.rem = rem;
    job.last = item.last_value;
    unique case (rem)
      2'd0: job.digits = {sat[5:0], 18'd0};
      2'd1: job.digits = {sat[11:0], 12'd0};
      2'd2: job.digits = {sat[17:0], 6'd0};
      default: job.digits = sat[23:0];
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sbce_queue.sv
// small queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module sbce_queue
  import sbce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbce_back.sv
// back end: emits characters, keeps the line count and sum, closes lines
`timescale 1ns / 1ps
`default_nettype none

module sbce_back
  import sbce_pkg::*;
#(
  parameter int LINE_CHARS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_beat_t out_data
);

  localparam logic [6:0] LINE_LIM = 7'(LINE_CHARS);

  logic        busy;
  phase_t      phase;
  logic [23:0] digits;
  logic [1:0]  rem;
  logic        last;
  logic        digits_done;
  logic [6:0]  line_count;
  logic [7:0]  line_sum;
  logic [2:0]  emit_cnt;

  phase_t      phase_next;
  logic [7:0]  cur_byte;
  logic        is_end;
  logic        step;
  logic        drop;
  logic [7:0]  digit_char;
  logic [6:0]  count_inc;
  logic        close;

  assign digit_char = {2'b00, digits[23:18]} + CHAR_BASE;
  assign count_inc = line_count + 7'd1;
  assign close = (count_inc >= LINE_LIM);
  assign drop = (emit_cnt == MAX_RESULTS);
  assign step = busy && (drop || !out_valid || out_ready);
  assign job_pop = job_valid && (!busy || (step && is_end));

  // byte of this step, its successor phase and whether it ends the item
  always_comb begin
    cur_byte = digit_char;
    is_end = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_DIGIT: begin
        cur_byte = digit_char;
        if (close || (rem == 2'd0 && last)) begin
          phase_next = PH_CHK;
        end else begin
          phase_next = PH_DIGIT;
          is_end = (rem == 2'd0);
        end
      end
      PH_CHK: begin
        cur_byte = {2'b00, line_sum[5:0] & DIGIT_MASK} + CHAR_BASE;
        phase_next = PH_LF;
      end
      default: begin
        cur_byte = LINE_FEED;
        phase_next = PH_DIGIT;
        is_end = digits_done;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      digits <= job.digits;
      rem <= job.rem;
      last <= job.last;
      digits_done <= 1'b0;
    end else if (step && phase == PH_DIGIT) begin
      digits <= {digits[17:0], 6'd0};
      digits_done <= (rem == 2'd0);
      if (rem != 2'd0) begin
        rem <= rem - 2'd1;
      end
    end
    if (step && !drop) begin
      out_data.out_char <= cur_byte;
      out_data.last_of_run <= is_end || (emit_cnt == MAX_RESULTS - 3'd1);
    end
  end

  // an item always ends on a step whose successor phase is PH_DIGIT
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= PH_DIGIT;
      line_count <= '0;
      line_sum <= '0;
      emit_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        if (phase == PH_DIGIT) begin
          line_count <= count_inc;
          line_sum <= line_sum + digit_char;
        end else if (phase == PH_CHK) begin
          line_count <= '0;
          line_sum <= '0;
        end
        phase <= phase_next;
      end
      if (job_pop) begin
        emit_cnt <= '0;
      end else if (step && !drop) begin
        emit_cnt <= emit_cnt + 3'd1;
      end
      if (job_pop) begin
        busy <= 1'b1;
      end else if (step && is_end) begin
        busy <= 1'b0;
      end
      if (step && !drop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/six_bit_char_encoder_with_line_checksum_core.sv
// top level of the six-bit character encoder with line checksum
// input channel in_valid/in_ready/in_data carries one value beat and its
// last flag; output channel out_valid/out_ready/out_data carries one byte
// beat, with last_of_run set on the final byte of each input value.
// cfg_we/cfg_wdata write chars_per_value (1 to 4); the user must do so only
// while the block is idle, the block itself does not enforce it. the back
// end sends one byte per cycle while out_ready is high and values wait: a
// value gives chars_per_value digits, plus a checksum and line feed pair
// for each line it closes. at most seven bytes reach the output per value
// and any beyond are skipped one a cycle. a two-entry queue sits between
// the front and back, so values keep being accepted while bytes drain.
// when the receiver stalls, the output register holds its byte and the
// queue fills, after which in_ready drops. reset clears the line count and
// sum, empties the queue and sets chars_per_value to 3.
`timescale 1ns / 1ps
`default_nettype none

module six_bit_char_encoder_with_line_checksum_core
  import sbce_pkg::*;
#(
  parameter int LINE_CHARS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_beat_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  logic [2:0] chars_per_value;
  job_t       front_job;
  job_t       head_job;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_value <= CHARS_RESET;
    end else if (cfg_we) begin
      chars_per_value <= cfg_wdata;
    end
  end

  assign in_ready = !q_full;

  sbce_front u_front (
    .item            (in_data),
    .chars_per_value (chars_per_value),
    .job             (front_job)
  );

  sbce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  sbce_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
